FILE: rtl/mepe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mepe_pkg: shared types and constants
// Widths, register map and reset values for the MED prediction error block.
// ----------------------------------------------------------------------------
package mepe_pkg;

  localparam int PIXEL_W    = 8;
  localparam int ERR_W      = 9;
  localparam int WIDTH_W    = 13;
  localparam int APB_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RESET = 13'd512;

  // Register index, taken from the top word address bit of paddr
  typedef enum logic {
    REG_IMAGE_WIDTH = 1'b0,
    REG_NONE        = 1'b1
  } reg_index_t;

endpackage
`default_nettype wire

FILE: rtl/mepe_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mepe_in_if: pixel input channel
// Valid/ready channel carrying one raster-order pixel and its frame mark.
// ----------------------------------------------------------------------------
interface mepe_in_if;
  logic                          valid;
  logic                          ready;
  logic [mepe_pkg::PIXEL_W-1:0]  pixel;
  logic                          frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface
`default_nettype wire

FILE: rtl/mepe_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mepe_out_if: prediction result channel
// Valid/ready channel carrying the even prediction and the signed error.
// ----------------------------------------------------------------------------
interface mepe_out_if;
  logic                               valid;
  logic                               ready;
  logic [mepe_pkg::PIXEL_W-1:0]       predicted;
  logic signed [mepe_pkg::ERR_W-1:0]  error;

  modport source (output valid, predicted, error, input ready);
  modport sink   (input valid, predicted, error, output ready);
endinterface
`default_nettype wire

FILE: rtl/mepe_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mepe_cfg: configuration registers
// APB-style slave holding the image width register.
// ----------------------------------------------------------------------------
module mepe_cfg (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [mepe_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [mepe_pkg::APB_DATA_W-1:0]      pwdata,
  output logic      [mepe_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                      pready,
  output logic      [mepe_pkg::WIDTH_W-1:0]         image_width
);

  mepe_pkg::reg_index_t reg_sel;
  logic                 wr_en;

  assign reg_sel = mepe_pkg::reg_index_t'(paddr[mepe_pkg::CFG_ADDR_W-1]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= mepe_pkg::IMAGE_WIDTH_RESET;
    end else if (wr_en && (reg_sel == mepe_pkg::REG_IMAGE_WIDTH)) begin
      image_width <= pwdata[mepe_pkg::WIDTH_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      mepe_pkg::REG_IMAGE_WIDTH:
        prdata = {{(mepe_pkg::APB_DATA_W-mepe_pkg::WIDTH_W){1'b0}}, image_width};
      default:
        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/mepe_line_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mepe_line_store: previous-row pixel memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mepe_line_store #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  wire logic                              clk,
  input  wire logic                              wr_en,
  input  wire logic [ADDR_W-1:0]                 wr_addr,
  input  wire logic [mepe_pkg::PIXEL_W-1:0]      wr_data,
  input  wire logic                              rd_en,
  input  wire logic [ADDR_W-1:0]                 rd_addr,
  output logic      [mepe_pkg::PIXEL_W-1:0]      rd_data
);

  logic [mepe_pkg::PIXEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mepe_med_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mepe_med_unit: median edge detector
// Forms the even-rounded MED prediction and the pixel error.
// ----------------------------------------------------------------------------
module mepe_med_unit (
  input  wire logic        [mepe_pkg::PIXEL_W-1:0]  left,
  input  wire logic        [mepe_pkg::PIXEL_W-1:0]  upper,
  input  wire logic        [mepe_pkg::PIXEL_W-1:0]  upper_left,
  input  wire logic        [mepe_pkg::PIXEL_W-1:0]  pixel,
  output logic             [mepe_pkg::PIXEL_W-1:0]  predicted,
  output logic signed      [mepe_pkg::ERR_W-1:0]    error
);

  logic [mepe_pkg::PIXEL_W-1:0] lo;
  logic [mepe_pkg::PIXEL_W-1:0] hi;
  logic [mepe_pkg::PIXEL_W-1:0] grad;
  logic [mepe_pkg::PIXEL_W-1:0] med;

  always_comb begin
    lo   = (left < upper) ? left : upper;
    hi   = (left < upper) ? upper : left;
    // Planar case lies strictly between lo and hi, so the wrapped sum is exact
    grad = left + upper - upper_left;
    priority if (upper_left <= lo) begin
      med = hi;
    end else if (upper_left >= hi) begin
      med = lo;
    end else begin
      med = grad;
    end
    // Round down to even
    predicted = {med[mepe_pkg::PIXEL_W-1:1], 1'b0};
    error     = $signed({1'b0, pixel} - {1'b0, predicted});
  end

endmodule
`default_nettype wire

FILE: rtl/med_even_prediction_error.sv
`default_nettype none
// ----------------------------------------------------------------------------
// med_even_prediction_error: MED prediction with even rounding
// Raster-order pixel stream in, even MED prediction and signed error out.
//
//   Channel   Kind        Dir   Payload
//   pixels    valid/ready in    pixel[7:0], frame_start
//   results   valid/ready out   predicted[7:0], error[8:0] signed
//   apb       APB write   in    image_width @ 0x0 (13 bits)
//
// One pixel per clock sustained while results is ready; an accepted pixel
// passes the line store read stage and then the result register.
// Reset (rst, synchronous) clears the column counter, neighbours and valids
// and sets the first-row flag; the line store itself is not cleared.
// A stall on results holds the result register and the read stage; input
// ready then drops only once both are full.
// ----------------------------------------------------------------------------
module med_even_prediction_error #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  mepe_in_if.sink                                   pixels,
  mepe_out_if.source                                results,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [mepe_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [mepe_pkg::APB_DATA_W-1:0]      pwdata,
  output logic      [mepe_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                      pready
);

  // Column counter width and the width used for the row-end compare
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CMPW = (CW + 1 > mepe_pkg::WIDTH_W) ? CW + 1 : mepe_pkg::WIDTH_W;

  logic [mepe_pkg::WIDTH_W-1:0] image_width;

  // Position in the frame, advanced at each accepted word
  logic [CW-1:0]   column_count;
  logic [CW-1:0]   column_count_next;
  logic            first_row;
  logic [CW-1:0]   col_cur;
  logic            fr_cur;
  logic [CMPW-1:0] col_inc;
  logic            row_end;

  // Read stage: waits for the line store data
  logic                          s1_valid;
  logic [CW-1:0]                 s1_col;
  logic                          s1_first_row;
  logic [mepe_pkg::PIXEL_W-1:0]  s1_pix;
  logic                          s1_fwd;
  logic [mepe_pkg::PIXEL_W-1:0]  s1_fwd_pix;
  logic                          s1_fire;

  logic [mepe_pkg::PIXEL_W-1:0]  left_pixel;
  logic [mepe_pkg::PIXEL_W-1:0]  upper_left_pixel;
  logic [mepe_pkg::PIXEL_W-1:0]  rd_data;

  logic [mepe_pkg::PIXEL_W-1:0]  nb_a;
  logic [mepe_pkg::PIXEL_W-1:0]  nb_b;
  logic [mepe_pkg::PIXEL_W-1:0]  nb_c;
  logic [mepe_pkg::PIXEL_W-1:0]  med_pred;
  logic signed [mepe_pkg::ERR_W-1:0] med_err;

  // Result register
  logic                              out_valid;
  logic [mepe_pkg::PIXEL_W-1:0]      out_pred;
  logic signed [mepe_pkg::ERR_W-1:0] out_err;

  logic in_accept;

  mepe_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .image_width (image_width)
  );

  // Advance the read stage whenever the result register is free or draining
  assign s1_fire      = s1_valid && (!out_valid || results.ready);
  assign pixels.ready = !s1_valid || s1_fire;
  assign in_accept    = pixels.valid && pixels.ready;

  // Frame start restarts at column zero on the first row
  always_comb begin
    col_cur = pixels.frame_start ? '0 : column_count;
    fr_cur  = pixels.frame_start || first_row;
    col_inc = CMPW'(col_cur) + CMPW'(1);
    // A zero width acts as one, a width beyond the store as its depth
    row_end = (col_inc >= CMPW'(image_width)) || (col_inc >= CMPW'(MAX_WIDTH));
    column_count_next = row_end ? '0 : col_inc[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      first_row    <= 1'b1;
    end else if (in_accept) begin
      column_count <= column_count_next;
      first_row    <= row_end ? 1'b0 : fr_cur;
    end
  end

  // Read the upper neighbour now; write the current pixel back when the
  // word leaves the read stage.
  mepe_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (CW)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_col),
    .wr_data (s1_pix),
    .rd_en   (in_accept),
    .rd_addr (col_cur),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col       <= col_cur;
      s1_first_row <= fr_cur;
      s1_pix       <= pixels.pixel;
      // Same entry written this cycle: forward it, the memory returns old data
      s1_fwd       <= s1_fire && (s1_col == col_cur);
      s1_fwd_pix   <= s1_pix;
    end
  end

  // Neighbours outside the frame read as zero
  always_comb begin
    nb_a = (s1_col == '0) ? '0 : left_pixel;
    nb_b = s1_first_row ? '0 : (s1_fwd ? s1_fwd_pix : rd_data);
    nb_c = ((s1_col == '0) || s1_first_row) ? '0 : upper_left_pixel;
  end

  mepe_med_unit u_med (
    .left       (nb_a),
    .upper      (nb_b),
    .upper_left (nb_c),
    .pixel      (s1_pix),
    .predicted  (med_pred),
    .error      (med_err)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= '0;
      upper_left_pixel <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (s1_fire) begin
        upper_left_pixel <= nb_b;
        left_pixel       <= s1_pix;
        out_valid        <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_pred <= med_pred;
      out_err  <= med_err;
    end
  end

  assign results.valid     = out_valid;
  assign results.predicted = out_pred;
  assign results.error     = out_err;

endmodule
`default_nettype wire

FILE: verif/tb_med_even_prediction_error.sv
// ----------------------------------------------------------------------------
// tb_med_even_prediction_error: self-checking bench for the MED predictor
// Streams raster-order pixels through the block under random gaps and stalls
// and checks every prediction and error word against a typed-in value or a
// bench-side model of the line store, neighbors and column counter. A short
// scripted run covers extremes, every MED branch, frame restarts and the width
// register limits; random frames of assorted widths and a short over-range one follow.
// ----------------------------------------------------------------------------
module tb_med_even_prediction_error;

  localparam int PIXEL_W    = mepe_pkg::PIXEL_W;
  localparam int ERR_W      = mepe_pkg::ERR_W;
  localparam int WIDTH_W    = mepe_pkg::WIDTH_W;
  localparam int APB_DATA_W = mepe_pkg::APB_DATA_W;
  localparam int CFG_ADDR_W = mepe_pkg::CFG_ADDR_W;
  localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RESET = mepe_pkg::IMAGE_WIDTH_RESET;

  localparam int MAX_W       = 4096;
  localparam int RAND_WORDS  = 400;
  localparam int WIDE_WORDS  = 24;
  localparam int GAP_PCT     = 28;
  localparam int MAX_REPORTS = 30;

  localparam logic [CFG_ADDR_W-1:0] WIDTH_ADDR = {mepe_pkg::REG_IMAGE_WIDTH, 2'b00};

  typedef struct packed {
    logic [PIXEL_W-1:0]       predicted;
    logic signed [ERR_W-1:0]  error;
  } result_t;

  // Per-word tag: a typed-in expectation overrides the model's answer
  typedef struct packed {
    logic     typed;
    result_t  want;
  } word_tag_t;

  typedef enum logic [0:0] {
    ROW_WORD      = 1'b0,
    ROW_SET_WIDTH = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [WIDTH_W-1:0]  width;
    logic [PIXEL_W-1:0]  pix;
    logic                fs;
    logic                typed;
    result_t             want;
  } script_row_t;

  typedef enum logic [1:0] {
    FILL_NOISE   = 2'd0,
    FILL_EXTREME = 2'd1,
    FILL_RAMP    = 2'd2
  } fill_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  mepe_in_if  pix_if ();
  mepe_out_if res_if ();

  med_even_prediction_error #(
    .MAX_WIDTH (MAX_W)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_if),
    .results (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Bench-side copy of the block state
  logic [PIXEL_W-1:0]  row_mem [MAX_W];
  logic [PIXEL_W-1:0]  left_px;
  logic [PIXEL_W-1:0]  upleft_px;
  int unsigned         col_cnt;
  bit                  top_row;
  logic [WIDTH_W-1:0]  width_reg;

  result_t    pending_results [$];
  word_tag_t  word_tags [$];

  int  words_sent;
  int  results_seen;
  int  err_count;
  int  width_writes;
  int  drains;
  bit  no_gaps;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the handshake locks up
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < MAX_REPORTS) begin
      $display("MISMATCH %s: got %0d, expected %0d (result #%0d)",
               what, got, want, results_seen);
    end
    err_count++;
  endtask

  // Work out the even MED prediction for one accepted pixel and advance
  // the line store, neighbors and column counter the way the block does.
  function automatic result_t predict_med_error(input logic [PIXEL_W-1:0] pix,
                                                input logic fs);
    int unsigned span;
    int unsigned col;
    logic [PIXEL_W-1:0] a, b, c, lo, hi, p;
    result_t r;
    span = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
    if (fs) begin
      col_cnt = 0;
      top_row = 1'b1;
    end
    col = col_cnt;
    a = (col == 0) ? '0 : left_px;
    b = top_row ? '0 : row_mem[col];
    c = (col == 0 || top_row) ? '0 : upleft_px;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      p = hi;
    end else if (c >= hi) begin
      p = lo;
    end else begin
      p = a + b - c;
    end
    p[0] = 1'b0;
    r.predicted = p;
    r.error = {1'b0, pix} - {1'b0, p};
    upleft_px = b;
    left_px = pix;
    row_mem[col] = pix;
    col++;
    if (col >= span) begin
      col = 0;
      top_row = 1'b0;
    end
    col_cnt = col;
    return r;
  endfunction

  // Track register writes and accepted pixels; queue one expectation per word
  always @(posedge clk) begin : track_pixels
    result_t r;
    word_tag_t tag;
    if (rst) begin
      left_px = '0;
      upleft_px = '0;
      col_cnt = 0;
      top_row = 1'b1;
      width_reg = IMAGE_WIDTH_RESET;
    end else begin
      if (psel && penable && pwrite && pready &&
          mepe_pkg::reg_index_t'(paddr[CFG_ADDR_W-1]) == mepe_pkg::REG_IMAGE_WIDTH) begin
        width_reg = pwdata[WIDTH_W-1:0];
      end
      if (pix_if.valid && pix_if.ready) begin
        r = predict_med_error(pix_if.pixel, pix_if.frame_start);
        tag = word_tags.pop_front();
        pending_results.push_back(tag.typed ? tag.want : r);
      end
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected", int'(res_if.predicted), -1);
      end else begin
        want = pending_results.pop_front();
        if (res_if.predicted !== want.predicted) begin
          report_mismatch("predicted", int'(res_if.predicted), int'(want.predicted));
        end
        if (res_if.error !== want.error) begin
          report_mismatch("error", int'(res_if.error), int'(want.error));
        end
      end
    end
  end

  // Result side: stall at random, except through the no-gap stretch
  always @(posedge clk) begin
    res_if.ready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
  end

  // Present one pixel word; idle at random first, hold until accepted
  task automatic send_word(input logic [PIXEL_W-1:0] pix, input logic fs,
                           input logic typed, input result_t want);
    word_tag_t tag;
    tag.typed = typed;
    tag.want = want;
    while (!no_gaps && $urandom_range(99) < GAP_PCT) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    word_tags.push_back(tag);
    pix_if.valid <= 1'b1;
    pix_if.pixel <= pix;
    pix_if.frame_start <= fs;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    words_sent++;
  endtask

  // Drop valid and hold off until every expected result word has come back
  task automatic drain_results();
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (results_seen != words_sent) @(posedge clk);
    drains++;
  endtask

  // Write image_width while the block is idle (setup, then access phase)
  task automatic set_image_width(input logic [WIDTH_W-1:0] w);
    drain_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= WIDTH_ADDR;
    pwdata <= APB_DATA_W'(w);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    width_writes++;
  endtask

  function automatic script_row_t word_row(input logic [PIXEL_W-1:0] pix, input logic fs);
    script_row_t s;
    s = '0;
    s.kind = ROW_WORD;
    s.pix = pix;
    s.fs = fs;
    return s;
  endfunction

  function automatic script_row_t typed_row(input logic [PIXEL_W-1:0] pix, input logic fs,
                                            input logic [PIXEL_W-1:0] pred,
                                            input logic signed [ERR_W-1:0] err);
    script_row_t s;
    s = word_row(pix, fs);
    s.typed = 1'b1;
    s.want.predicted = pred;
    s.want.error = err;
    return s;
  endfunction

  function automatic script_row_t width_row(input logic [WIDTH_W-1:0] w);
    script_row_t s;
    s = '0;
    s.kind = ROW_SET_WIDTH;
    s.width = w;
    return s;
  endfunction

  initial begin : stimulus
    script_row_t script [28];
    int rand_words;
    int big_words;
    int directed_words;
    int cur_w;
    int eff;
    int len;
    int k;
    int base;
    int dx;
    int dy;
    int v;
    logic fs;
    fill_t fill;

    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pix_if.valid <= 1'b0;
    pix_if.pixel <= '0;
    pix_if.frame_start <= 1'b0;
    no_gaps = 1'b0;
    words_sent = 0;
    results_seen = 0;
    err_count = 0;
    width_writes = 0;
    drains = 0;

    // Scripted run. The first rows use the reset width of 512.
    script = '{
      typed_row(8'd255, 1'b1, 8'd0,   9'sd255),   // top-left corner sees only zeros
      typed_row(8'd0,   1'b0, 8'd254, -9'sd254),  // left of 255 rounds down to 254
      typed_row(8'd1,   1'b0, 8'd0,   9'sd1),
      width_row(13'd3),
      typed_row(8'd10,  1'b1, 8'd0,   9'sd10),
      typed_row(8'd20,  1'b0, 8'd10,  9'sd10),
      typed_row(8'd30,  1'b0, 8'd20,  9'sd10),
      word_row(8'd40,  1'b0),                     // left column: upper only
      word_row(8'd5,   1'b0),                     // upper-left below both
      word_row(8'd33,  1'b0),                     // in between: a+b-c is odd
      word_row(8'd0,   1'b0),
      word_row(8'd255, 1'b0),                     // upper-left above both
      typed_row(8'd128, 1'b1, 8'd0,   9'sd128),   // frame restart mid-row
      word_row(8'd7,   1'b0),
      width_row(13'd0),                           // zero acts as one
      typed_row(8'd200, 1'b1, 8'd0,   9'sd200),
      word_row(8'd201, 1'b0),
      word_row(8'd255, 1'b0),
      width_row(13'd1),
      typed_row(8'd0,   1'b1, 8'd0,   9'sd0),
      typed_row(8'd255, 1'b0, 8'd0,   9'sd255),
      width_row(13'd4096),
      typed_row(8'd77,  1'b1, 8'd0,   9'sd77),
      word_row(8'd254, 1'b0),
      width_row(13'd2),                           // shrink with the column past the end
      word_row(8'd9,   1'b0),
      word_row(8'd100, 1'b0),
      word_row(8'd128, 1'b0)
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_SET_WIDTH) begin
        set_image_width(script[i].width);
      end else begin
        send_word(script[i].pix, script[i].fs, script[i].typed, script[i].want);
      end
    end
    directed_words = words_sent;
    cur_w = 2;

    // Random frames: every frame opens with a frame start, so a wider row
    // never reads line store entries that were not written.
    rand_words = 0;
    while (rand_words < RAND_WORDS) begin
      if ($urandom_range(3) != 0) begin
        if ($urandom_range(9) == 0) begin
          cur_w = $urandom_range(16, 48);
        end else begin
          cur_w = $urandom_range(0, 15);
        end
        set_image_width(WIDTH_W'(cur_w));
      end
      eff = (cur_w == 0) ? 1 : cur_w;
      len = eff * $urandom_range(1, 5) + $urandom_range(0, eff);
      fill = fill_t'($urandom_range(2));
      base = $urandom_range(255);
      dx = $urandom_range(0, 12) - 6;
      dy = $urandom_range(0, 12) - 6;
      for (k = 0; k < len && rand_words < RAND_WORDS; k++) begin
        // Run both sides flat out for a stretch in the middle
        no_gaps = (rand_words >= 150 && rand_words < 260);
        fs = (k == 0);
        if (k != 0) begin
          if ($urandom_range(99) < 2) begin
            fs = 1'b1;                            // stray frame start
          end
          if ($urandom_range(99) < 2 || rand_words == 300) begin
            drain_results();
          end
          if ($urandom_range(99) < 2) begin
            // Shrinking mid-frame only ever reads entries already written
            cur_w = $urandom_range(0, cur_w);
            set_image_width(WIDTH_W'(cur_w));
          end
        end
        case (fill)
          FILL_EXTREME: v = $urandom_range(1) ? 255 : $urandom_range(0, 3);
          FILL_RAMP: begin
            v = base + (k % eff) * dx + (k / eff) * dy + $urandom_range(0, 6) - 3;
            v = (v < 0) ? 0 : ((v > 255) ? 255 : v);
          end
          default: v = $urandom_range(255);
        endcase
        send_word(PIXEL_W'(v), fs, 1'b0, '0);
        rand_words++;
      end
    end
    no_gaps = 1'b0;

    // Short frame with an over-range width: it clamps to 4096 columns,
    // so the row runs on without a wrap.
    set_image_width({WIDTH_W{1'b1}});
    big_words = words_sent;
    for (k = 0; k < WIDE_WORDS; k++) begin
      send_word(PIXEL_W'($urandom_range(255)), k == 0, 1'b0, '0);
    end
    big_words = words_sent - big_words;

    drain_results();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch("expected results never produced", 0, pending_results.size());
    end

    $display("Covered %0d pixel words: %0d scripted, %0d at an over-range width, rest random",
             words_sent, directed_words, big_words);
    $display("Checked %0d result words over %0d width writes and %0d idle drains",
             results_seen, width_writes, drains);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
